@@ hw/rtl/pip_pkg.sv @@
// Shared types and constants of the point-in-polygon test.
package pip_pkg;

  // Polygon store depth and coordinate width.
  localparam int MAX_VERTICES = 8;
  localparam int COORD_WIDTH  = 16;

  // Widths of the fixed word and register fields.
  localparam int INDEX_WIDTH = 3;
  localparam int COUNT_WIDTH = 4;

  // Store address, vertex number, edge difference and product widths.
  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int NUM_W  = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;

  // Vertex count after reset.
  localparam logic [COUNT_WIDTH-1:0] VCOUNT_RESET = COUNT_WIDTH'(3);

  // Operation codes of an input word.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // Step strobes from the sequencer to the edge datapath.
  typedef struct packed {
    logic clear;
    logic load_point;
    logic load_prev;
    logic setup;
    logic mul_a;
    logic mul_b;
    logic cmp;
  } ctrl_t;

endpackage

@@ hw/rtl/pip_if.sv @@
// Input channel: vertex writes and point queries.
interface pip_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [pip_pkg::INDEX_WIDTH-1:0]     vertex_index;
  pip_pkg::coord_t                     coord_x;
  pip_pkg::coord_t                     coord_y;

  modport source (output valid, operation, vertex_index, coord_x, coord_y, input ready);
  modport sink   (input valid, operation, vertex_index, coord_x, coord_y, output ready);
endinterface

// Output channel: one inside flag per query.
interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

@@ hw/rtl/pip_vstore.sv @@
// Vertex memory: one write port, one read port with registered data.
module pip_vstore (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [pip_pkg::ADDR_W-1:0]  waddr_i,
  input  pip_pkg::coord_t             wx_i,
  input  pip_pkg::coord_t             wy_i,
  input  logic                        re_i,
  input  logic [pip_pkg::ADDR_W-1:0]  raddr_i,
  output pip_pkg::coord_t             rx_o,
  output pip_pkg::coord_t             ry_o
);

  pip_pkg::coord_t mem_x [pip_pkg::MAX_VERTICES];
  pip_pkg::coord_t mem_y [pip_pkg::MAX_VERTICES];
  pip_pkg::coord_t rx_q;
  pip_pkg::coord_t ry_q;

  // Write a vertex.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_x[waddr_i] <= wx_i;
      mem_y[waddr_i] <= wy_i;
    end
  end

  // Read a vertex; the data is registered, so it shows up in the cycle after the read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rx_q <= mem_x[raddr_i];
      ry_q <= mem_y[raddr_i];
    end
  end

  assign rx_o = rx_q;
  assign ry_o = ry_q;

endmodule

@@ hw/rtl/pip_edge.sv @@
// Edge datapath: straddle test, one shared multiplier used twice per edge,
// exact product compare and the crossing parity.
module pip_edge (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pip_pkg::ctrl_t   ctrl_i,
  input  pip_pkg::coord_t  pt_x_i,
  input  pip_pkg::coord_t  pt_y_i,
  input  pip_pkg::coord_t  vx_i,
  input  pip_pkg::coord_t  vy_i,
  output logic             inside_o
);

  localparam int W = pip_pkg::COORD_WIDTH;

  // Query point, previous vertex (j) and current vertex (i).
  pip_pkg::coord_t px_q, py_q, jx_q, jy_q, ix_q, iy_q;

  // Edge terms and products.
  logic signed [pip_pkg::DIFF_W-1:0] a_q, b_q, a_d, b_d;
  logic [W-1:0]                      d_q, t_q, d_d, t_d;
  logic                              strad_q, strad_d;
  logic signed [pip_pkg::PROD_W-1:0] prod_a_q, prod_b_q, prod;
  logic                              parity_q;

  logic                              up, down;
  logic signed [pip_pkg::DIFF_W-1:0] dy_up, dy_dn, ty_up, ty_dn;
  logic signed [pip_pkg::DIFF_W-1:0] op_s;
  logic signed [pip_pkg::DIFF_W-1:0] op_f;

  function automatic logic signed [pip_pkg::DIFF_W-1:0] sext(pip_pkg::coord_t v);
    return {v[W-1], v};
  endfunction

  // Edge setup: does the edge straddle the point's y, and its x terms.
  always_comb begin
    up      = (vy_i <= py_q) && (py_q < jy_q);
    down    = (jy_q <= py_q) && (py_q < vy_i);
    dy_up   = sext(jy_q) - sext(vy_i);
    dy_dn   = sext(vy_i) - sext(jy_q);
    ty_up   = sext(py_q) - sext(vy_i);
    ty_dn   = sext(vy_i) - sext(py_q);
    d_d     = up ? dy_up[W-1:0] : dy_dn[W-1:0];
    t_d     = up ? ty_up[W-1:0] : ty_dn[W-1:0];
    strad_d = up || down;
    a_d     = sext(px_q) - sext(vx_i);
    b_d     = sext(jx_q) - sext(vx_i);
  end

  // Shared multiplier: (x - xi) * D first, then (xj - xi) * T.
  always_comb begin
    op_s = ctrl_i.mul_b ? b_q : a_q;
    op_f = ctrl_i.mul_b ? {1'b0, t_q} : {1'b0, d_q};
    prod = pip_pkg::PROD_W'(op_s) * pip_pkg::PROD_W'(op_f);
  end

  // Point, vertex and edge registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_point) begin
      px_q <= pt_x_i;
      py_q <= pt_y_i;
    end
    if (ctrl_i.load_prev) begin
      jx_q <= vx_i;
      jy_q <= vy_i;
    end else if (ctrl_i.cmp) begin
      jx_q <= ix_q;
      jy_q <= iy_q;
    end
    if (ctrl_i.setup) begin
      ix_q    <= vx_i;
      iy_q    <= vy_i;
      a_q     <= a_d;
      b_q     <= b_d;
      d_q     <= d_d;
      t_q     <= t_d;
      strad_q <= strad_d;
    end
    if (ctrl_i.mul_a) begin
      prod_a_q <= prod;
    end
    if (ctrl_i.mul_b) begin
      prod_b_q <= prod;
    end
  end

  // Crossing parity: toggles when the point lies left of the crossing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      parity_q <= 1'b0;
    end else if (ctrl_i.cmp && strad_q && (prod_a_q < prod_b_q)) begin
      parity_q <= ~parity_q;
    end
  end

  assign inside_o = parity_q;

endmodule

@@ hw/rtl/point_in_polygon_test.sv @@
// Channel  Dir  Handshake        Payload
// in_i     in   valid / ready    operation, vertex_index, coord_x, coord_y
// out_o    out  valid / ready    inside_res
// cfg      in   cfg_we_i         cfg_wdata_i (vertex_count)
//
// A query first fetches the closing vertex, then takes four steps per edge
// on the shared multiplier (setup, two products, compare). A query with no
// vertices goes straight to the done step. Reset clears the sequencer and
// sets vertex_count to 3; the vertex memory holds no reset value.
// A waiting result sits in the output register while new words are taken.
module point_in_polygon_test (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pip_pkg::COUNT_WIDTH-1:0]   cfg_wdata_i,
  pip_in_if.sink                            in_i,
  pip_out_if.source                         out_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREV  = 7'b0000010,
    S_SETUP = 7'b0000100,
    S_MULA  = 7'b0001000,
    S_MULB  = 7'b0010000,
    S_CMP   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e                           state_q, state_d;
  logic [pip_pkg::COUNT_WIDTH-1:0]  vcount_q;
  logic [pip_pkg::NUM_W-1:0]        n_q, n_d, n_cfg;
  logic [pip_pkg::ADDR_W-1:0]       idx_q, idx_d;
  logic                             out_valid_q, out_valid_d;
  logic                             out_inside_q, out_inside_d;

  pip_pkg::ctrl_t                   ctrl;
  logic                             in_acc, last, out_load;
  logic                             we, re;
  logic [pip_pkg::ADDR_W-1:0]       raddr;
  pip_pkg::coord_t                  rx, ry;
  logic                             inside_flag;

  // Vertex count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= pip_pkg::VCOUNT_RESET;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  // Count in use, saturated at the store depth.
  assign n_cfg = (32'(vcount_q) > pip_pkg::MAX_VERTICES) ?
                 pip_pkg::NUM_W'(pip_pkg::MAX_VERTICES) : pip_pkg::NUM_W'(vcount_q);

  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign last     = (pip_pkg::NUM_W'(idx_q) + pip_pkg::NUM_W'(1)) == n_q;
  assign we       = in_acc && (in_i.operation == pip_pkg::OP_WRITE) &&
                    (32'(in_i.vertex_index) < pip_pkg::MAX_VERTICES);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  // Sequencer: walk the edges from the closing one, four steps each.
  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    idx_d   = idx_q;
    ctrl    = '0;
    re      = 1'b0;
    raddr   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (in_i.operation == pip_pkg::OP_QUERY)) begin
          ctrl.clear      = 1'b1;
          ctrl.load_point = 1'b1;
          n_d             = n_cfg;
          if (n_cfg == '0) begin
            state_d = S_DONE;
          end else begin
            re      = 1'b1;
            raddr   = pip_pkg::ADDR_W'(n_cfg - pip_pkg::NUM_W'(1));
            state_d = S_PREV;
          end
        end
      end
      S_PREV: begin
        ctrl.load_prev = 1'b1;
        re             = 1'b1;
        raddr          = '0;
        idx_d          = '0;
        state_d        = S_SETUP;
      end
      S_SETUP: begin
        ctrl.setup = 1'b1;
        state_d    = S_MULA;
      end
      S_MULA: begin
        ctrl.mul_a = 1'b1;
        state_d    = S_MULB;
      end
      S_MULB: begin
        ctrl.mul_b = 1'b1;
        state_d    = S_CMP;
      end
      S_CMP: begin
        ctrl.cmp = 1'b1;
        if (last) begin
          state_d = S_DONE;
        end else begin
          idx_d   = idx_q + pip_pkg::ADDR_W'(1);
          re      = 1'b1;
          raddr   = idx_q + pip_pkg::ADDR_W'(1);
          state_d = S_SETUP;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: holds a result until the sink takes it.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_inside_d = out_inside_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_inside_d = inside_flag;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    out_inside_q <= out_inside_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.inside_res = out_inside_q;

  pip_vstore u_vstore (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pip_pkg::ADDR_W'(in_i.vertex_index)),
    .wx_i    (in_i.coord_x),
    .wy_i    (in_i.coord_y),
    .re_i    (re),
    .raddr_i (raddr),
    .rx_o    (rx),
    .ry_o    (ry)
  );

  pip_edge u_edge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .pt_x_i   (in_i.coord_x),
    .pt_y_i   (in_i.coord_y),
    .vx_i     (rx),
    .vy_i     (ry),
    .inside_o (inside_flag)
  );

  // A query always starts the edge walk or the empty-polygon answer.
  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.operation == pip_pkg::OP_QUERY) |=> state_q != S_IDLE)
    else $error("query accepted but sequencer stayed idle");

  // The edge index stays within the vertices in use.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SETUP |-> 32'(idx_q) < 32'(n_q))
    else $error("edge index beyond vertex count");

  // A result appears only from the done step.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result raised outside the done step");

endmodule

@@ dv/point_in_polygon_test_checker.sv @@
// Watches both channels and the register port of the polygon test, keeps its
// own copy of the vertex store and the vertex count, works out the inside
// flag of every accepted query and compares it with the flag the block returns.
module point_in_polygon_test_checker
  import pip_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [COUNT_WIDTH-1:0] cfg_wdata_i,
  input  logic                   word_valid_i,
  input  logic                   word_ready_i,
  input  logic                   operation_i,
  input  logic [INDEX_WIDTH-1:0] vertex_index_i,
  input  coord_t                 coord_x_i,
  input  coord_t                 coord_y_i,
  input  logic                   flag_valid_i,
  input  logic                   flag_ready_i,
  input  logic                   inside_res_i,
  output int                     errors_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Mirror of the polygon and the register.
  coord_t                 poly_x [MAX_VERTICES];
  coord_t                 poly_y [MAX_VERTICES];
  logic [COUNT_WIDTH-1:0] vertex_count;

  // Inside flags of accepted queries, oldest first.
  logic inside_q [$];
  logic wanted;
  int   err_count = 0;

  assign errors_o = err_count;

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    err_count++;
  endtask

  // Even-odd crossing count of the point against the stored polygon. The
  // crossing x is compared exactly by cross-multiplying with the edge rise.
  function automatic logic crossing_parity(input coord_t px, input coord_t py);
    int     n;
    int     i;
    int     j;
    longint x;
    longint y;
    longint xi;
    longint yi;
    longint xj;
    longint yj;
    longint rise;
    longint reach;
    logic   parity;
    parity = 1'b0;
    x = longint'(px);
    y = longint'(py);
    n = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
    j = n - 1;
    for (i = 0; i < n; i++) begin
      xi = longint'(poly_x[i]);
      yi = longint'(poly_y[i]);
      xj = longint'(poly_x[j]);
      yj = longint'(poly_y[j]);
      rise = 0;
      reach = 0;
      // The low end of the edge is included, the high end excluded.
      if (yi <= y && y < yj) begin
        rise = yj - yi;
        reach = y - yi;
      end else if (yj <= y && y < yi) begin
        rise = yi - yj;
        reach = yi - y;
      end
      if (rise != 0 && (x - xi) * rise < (xj - xi) * reach) begin
        parity = ~parity;
      end
      j = i;
    end
    return parity;
  endfunction

  // Results are retired before the words of the same edge are taken in, so
  // a query never meets its own flag in one cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count = VCOUNT_RESET;
      inside_q.delete();
      pending_o <= 0;
    end else begin
      if (flag_valid_i && flag_ready_i) begin
        if (inside_q.size() == 0) begin
          report_mismatch($sformatf("inside flag %0b with no query waiting", inside_res_i));
        end else begin
          wanted = inside_q.pop_front();
          if (inside_res_i !== wanted) begin
            report_mismatch($sformatf("inside_res got %b, want %b", inside_res_i, wanted));
          end
        end
      end
      if (cfg_we_i) begin
        vertex_count = cfg_wdata_i;
      end
      if (word_valid_i && word_ready_i) begin
        if (operation_i == OP_WRITE) begin
          poly_x[vertex_index_i] = coord_x_i;
          poly_y[vertex_index_i] = coord_y_i;
        end else begin
          inside_q.push_back(crossing_parity(coord_x_i, coord_y_i));
        end
      end
      pending_o <= inside_q.size();
    end
  end

endmodule

@@ dv/point_in_polygon_test_tb.sv @@
// Stimulus and verdict for the polygon test; the checker beside the block
// does all prediction and comparison.
module point_in_polygon_test_tb;
  import pip_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SEGMENTS     = 24;
  localparam int QUERIES      = 48;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [COUNT_WIDTH-1:0] cfg_wdata_i;
  int                     errors;
  int                     pending;
  int                     idle_pct = 0;
  int                     stall_pct = 0;
  int                     cycles = 0;

  // Stimulus-side copy of the polygon, used only to aim queries at ties.
  coord_t poly_x [MAX_VERTICES];
  coord_t poly_y [MAX_VERTICES];

  pip_in_if  in_ch ();
  pip_out_if out_ch ();

  point_in_polygon_test dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  point_in_polygon_test_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .word_valid_i   (in_ch.valid),
    .word_ready_i   (in_ch.ready),
    .operation_i    (in_ch.operation),
    .vertex_index_i (in_ch.vertex_index),
    .coord_x_i      (in_ch.coord_x),
    .coord_y_i      (in_ch.coord_y),
    .flag_valid_i   (out_ch.valid),
    .flag_ready_i   (out_ch.ready),
    .inside_res_i   (out_ch.inside_res),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The result side stalls at random at the current phase's rate.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("** point_in_polygon_test: FAILED **");
    $finish;
  end

  // Offers one word, with a random gap first, and waits until it is taken.
  task automatic send_word(input logic op, input logic [INDEX_WIDTH-1:0] idx,
                           input coord_t x, input coord_t y);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.vertex_index <= idx;
    in_ch.coord_x      <= x;
    in_ch.coord_y      <= y;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (op == OP_WRITE) begin
      poly_x[idx] = x;
      poly_y[idx] = y;
    end
  endtask

  task automatic write_vertex(input int idx, input int x, input int y);
    send_word(OP_WRITE, INDEX_WIDTH'(idx), coord_t'(x), coord_t'(y));
  endtask

  // The index field is ignored by a query, so it is left random.
  task automatic query_point(input int x, input int y);
    send_word(OP_QUERY, INDEX_WIDTH'($urandom), coord_t'(x), coord_t'(y));
  endtask

  // Changes the vertex count once the block has gone quiet.
  task automatic set_count(input int n);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= COUNT_WIDTH'(n);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // A coordinate drawn from the full range, a tiny grid, the extremes or a middle range.
  function automatic int pick_coord(input int mode);
    case (mode)
      0: return int'(coord_t'($urandom));
      1: return $urandom_range(0, 12) - 6;
      2: begin
        case ($urandom_range(0, 4))
          0: return -32768;
          1: return 32767;
          2: return -1;
          3: return 0;
          default: return 1;
        endcase
      end
      default: return $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  // Mostly the counts that make real polygons, sometimes any register value.
  function automatic int pick_count();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 15);
    return $urandom_range(3, 8);
  endfunction

  initial begin
    int seg;
    int k;
    int mode;
    int slot;

    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= OP_WRITE;
    in_ch.vertex_index <= '0;
    in_ch.coord_x      <= '0;
    in_ch.coord_y      <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fill every slot before any query, corners of the range first.
    write_vertex(0, -32768, -32768);
    write_vertex(1, 32767, -32768);
    write_vertex(2, 32767, 32767);
    write_vertex(3, -32768, 32767);
    write_vertex(4, 0, 0);
    write_vertex(5, 100, -50);
    write_vertex(6, -1, 1);
    write_vertex(7, 16384, -16384);

    // Count after reset: the lower-right half of the full square.
    query_point(100, 0);
    query_point(-100, 0);
    query_point(0, 0);
    query_point(0, -32768);
    query_point(32767, 32767);
    query_point(-32768, -32768);

    // The full square, with horizontal top and bottom edges.
    set_count(4);
    query_point(0, 0);
    query_point(32767, 0);
    query_point(-32768, 0);
    query_point(0, 32767);

    // No edges at all, saturation, and the degenerate counts.
    set_count(0);
    query_point(0, 0);
    set_count(15);
    query_point(1, -1);
    set_count(1);
    query_point(0, 0);
    set_count(2);
    query_point(0, 0);
    set_count(8);
    query_point(0, 0);
    query_point(50, -20);

    // Random: a fresh polygon per segment, then queries with a few rewrites.
    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 78; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      set_count(pick_count());
      mode = $urandom_range(0, 3);
      for (k = 0; k < MAX_VERTICES; k++) begin
        write_vertex(k, pick_coord(mode), pick_coord(mode));
      end
      repeat (QUERIES) begin
        slot = $urandom_range(0, MAX_VERTICES - 1);
        case ($urandom_range(0, 7))
          0: write_vertex(slot, pick_coord(mode), pick_coord(mode));
          // Aim at a vertex or its row and column to provoke exact ties.
          1, 2: query_point(int'(poly_x[slot]) + $urandom_range(0, 2) - 1,
                            int'(poly_y[slot]) + $urandom_range(0, 2) - 1);
          3: query_point(pick_coord(mode), int'(poly_y[slot]));
          4: query_point(pick_coord(0), pick_coord(0));
          default: query_point(pick_coord(mode), pick_coord(mode));
        endcase
      end
    end

    // Drain and give the verdict.
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("** point_in_polygon_test: PASSED **");
    end else begin
      $display("** point_in_polygon_test: FAILED **");
    end
    $finish;
  end

endmodule
